// ===== sv/round_robin_scheduler_core_macros.svh =====
// Assertion macros for the round-robin scheduler core.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rrs_pkg.sv =====
// Shared types and constants of the round-robin scheduler core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package rrs_pkg;

  localparam int IDX_W = 4;
  localparam int TQ_W  = 16;
  localparam logic [TQ_W-1:0] TQ_RESET = 16'd4;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FETCH,
    ST_LOOK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;    // latch the incoming item
    logic push;    // append the latched arrival at the tail
    logic rotate;  // pop the head, re-append it unless done, reload countdown
    logic emit;    // load the result register
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic full;
    logic rotate_due;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/round_robin_scheduler_core.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: req_type; tdata: arrival_index, head_done
// m_        out  m_tvalid/m_tready  tuser: sched_valid, arrival_dropped; tdata: sched_index
// cfg_      in   cfg_we             cfg_wdata: time_quantum
//
// One item at a time. An accepted arrival passes IDLE and DECIDE; a dropped arrival
// adds EMIT, a tick LOOK and EMIT, and a rotating head FETCH before LOOK; the extra
// states come from the registered read port of the ring RAM, read once for the old
// head and once for the new one. Reset is synchronous: ring empty, head 0, time_quantum
// and the countdown 4. A result waits in the output register while m_tready is low;
// the next item is accepted meanwhile and stalls only when it has a result.
//
// Top level of the round-robin scheduler core. Depends on rrs_pkg, rrs_ctrl,
// rrs_dp (with rrs_ram) and round_robin_scheduler_core_macros.svh.
`default_nettype none
`include "round_robin_scheduler_core_macros.svh"

module round_robin_scheduler_core
  import rrs_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration
  input  wire logic             cfg_we,
  input  wire logic [TQ_W-1:0]  cfg_wdata,   // time_quantum
  // items in
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,     // [3:0] arrival_index, [4] head_done, [7:5] zero
  input  wire logic             s_tuser,     // [0] req_type
  // results out
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [7:0]       m_tdata,     // [3:0] sched_index, [7:4] zero
  output logic      [1:0]       m_tuser      // [0] sched_valid, [1] arrival_dropped
);

  cmd_t             cmd;
  status_t          status;
  logic             sched_valid;
  logic [IDX_W-1:0] sched_index;
  logic             arrival_dropped;

  // Sequencer: accept, decide, fetch/rotate, look up the head, emit.
  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Ring storage, pointers, quantum countdown and output register.
  rrs_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .in_req_type         (s_tuser),
    .in_arrival_index    (s_tdata[IDX_W-1:0]),
    .in_head_done        (s_tdata[IDX_W]),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .m_tvalid            (m_tvalid),
    .m_tready            (m_tready),
    .out_sched_valid     (sched_valid),
    .out_sched_index     (sched_index),
    .out_arrival_dropped (arrival_dropped)
  );

  // Pack the result fields; pad tdata with zeros.
  assign m_tdata = {{(8 - IDX_W){1'b0}}, sched_index};
  assign m_tuser = {arrival_dropped, sched_valid};

  // Hold off new items until the one in flight has finished.
  `RRS_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "second item accepted while busy")

  // Never append to a full ring.
  `RRS_ASSERT_NOW(a_no_push_full, clk, rst, cmd.push, !status.full, "push into full ring")

  // A drop report never names a scheduled process.
  `RRS_ASSERT_NOW(a_drop_idle, clk, rst, m_tvalid && m_tuser[1], !m_tuser[0] && (m_tdata == 8'd0), "drop result carries a schedule")

endmodule

`default_nettype wire

// ===== sv/rrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/rrs_ctrl.sv =====
// Controller state machine of the round-robin scheduler core.
// Depends on rrs_pkg; drives commands to rrs_dp from its status.
`default_nettype none

module rrs_ctrl
  import rrs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!status.is_tick) begin
          if (status.full) begin
            state_next = ST_EMIT;
          end else begin
            cmd.push   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (status.rotate_due) begin
          state_next = ST_FETCH;
        end else begin
          state_next = ST_LOOK;
        end
      end
      ST_FETCH: begin
        // head entry read data is valid now
        cmd.rotate = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        // read of the (new) head is in flight
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/rrs_dp.sv =====
// Datapath of the round-robin scheduler core: ring RAM, pointers, countdown
// and result register. Depends on rrs_pkg and rrs_ram; driven by rrs_ctrl.
`default_nettype none

module rrs_dp
  import rrs_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output status_t               status,
  input  wire logic             in_req_type,
  input  wire logic [IDX_W-1:0] in_arrival_index,
  input  wire logic             in_head_done,
  input  wire logic             cfg_we,
  input  wire logic [TQ_W-1:0]  cfg_wdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic                  out_sched_valid,
  output logic      [IDX_W-1:0] out_sched_index,
  output logic                  out_arrival_dropped
);

  localparam int PW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  logic             req_q;
  logic [IDX_W-1:0] idx_q;
  logic             done_q;
  logic [PW-1:0]    head;
  logic [CW-1:0]    count;
  logic [TQ_W-1:0]  quantum_left;
  logic [TQ_W-1:0]  time_quantum;

  logic [CW:0]      tail_sum;
  logic [CW:0]      tail_wrap;
  logic [PW-1:0]    tail_pos;
  logic [PW-1:0]    head_inc;
  logic             ram_we;
  logic [IDX_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_rdata;
  logic             out_free;

  // Tail slot = (head + count) mod depth; the sum stays below twice the depth.
  always_comb begin
    tail_sum  = (CW+1)'(head) + (CW+1)'(count);
    tail_wrap = tail_sum - (CW+1)'(MAX_PROCS);
    if (tail_sum >= (CW+1)'(MAX_PROCS)) begin
      tail_pos = tail_wrap[PW-1:0];
    end else begin
      tail_pos = tail_sum[PW-1:0];
    end
    head_inc = (head == PW'(MAX_PROCS - 1)) ? '0 : head + PW'(1);
  end

  assign ram_we    = cmd.push | (cmd.rotate & ~done_q);
  assign ram_wdata = cmd.push ? idx_q : ram_rdata;

  rrs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PROCS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_pos),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (ram_rdata)
  );

  assign out_free = ~m_tvalid | m_tready;

  always_comb begin
    status.is_tick    = (req_q == REQ_TICK);
    status.full       = (count == CW'(MAX_PROCS));
    status.rotate_due = (count != '0) && ((quantum_left == '0) || done_q);
    status.out_free   = out_free;
  end

  // Latched item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= in_req_type;
      idx_q  <= in_arrival_index;
      done_q <= in_head_done;
    end
  end

  // Ring pointers, countdown and quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      count        <= '0;
      time_quantum <= TQ_RESET;
      quantum_left <= TQ_RESET;
    end else begin
      if (cfg_we) begin
        time_quantum <= cfg_wdata;
      end
      if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.rotate) begin
        head         <= head_inc;
        quantum_left <= time_quantum;
        if (done_q) begin
          count <= count - CW'(1);
        end
      end else if (cmd.emit && req_q == REQ_TICK) begin
        if (count == '0) begin
          quantum_left <= '0;
        end else if (quantum_left != '0) begin
          quantum_left <= quantum_left - TQ_W'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (req_q == REQ_TICK && count != '0) begin
        out_sched_valid <= 1'b1;
        out_sched_index <= ram_rdata;
      end else begin
        out_sched_valid <= 1'b0;
        out_sched_index <= '0;
      end
      out_arrival_dropped <= (req_q == REQ_ARRIVAL);
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_round_robin_scheduler_core.sv =====
// Self-checking testbench for round_robin_scheduler_core: drives arrival and tick items,
// predicts every schedule result and compares it with the result stream.
// Depends on rrs_pkg and the round_robin_scheduler_core RTL.
`timescale 1ns / 100ps

module tb_round_robin_scheduler_core
  import rrs_pkg::*;
;

  localparam int RING_SLOTS  = 16;
  localparam int CYCLE_LIMIT = 300000;
  // An accepted arrival gives no result, so let the block settle before a register write.
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 240;

  // One schedule result as it leaves the block.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic             dropped;
  } grant_t;

  // Scoreboard: keeps its own copy of the ring and the countdown and
  // the queue of schedule results still to come.
  class sched_scoreboard;
    logic [IDX_W-1:0] ring_slot [RING_SLOTS];
    int               head_pos;
    int               occupancy;
    logic [TQ_W-1:0]  slice_left;
    logic [TQ_W-1:0]  slice_len;
    grant_t           due_grants[$];
    int               fail_count;

    function void clear();
      foreach (ring_slot[i]) ring_slot[i] = '0;
      head_pos   = 0;
      occupancy  = 0;
      slice_len  = TQ_RESET;
      slice_left = TQ_RESET;
      due_grants.delete();
      fail_count = 0;
    endfunction

    // Predict the result of one accepted item.
    function void note_item(logic req, logic [IDX_W-1:0] idx, logic done);
      grant_t           g;
      logic [IDX_W-1:0] old_head;
      g = '0;
      if (req == REQ_ARRIVAL) begin
        if (occupancy >= RING_SLOTS) begin
          g.dropped = 1'b1;
          due_grants.insert(due_grants.size(), g);
        end else begin
          ring_slot[(head_pos + occupancy) % RING_SLOTS] = idx;
          occupancy++;
        end
        return;
      end
      // tick: rotate or retire the head when its slice ran out or it finished
      if (occupancy > 0 && (slice_left == 0 || done)) begin
        old_head = ring_slot[head_pos];
        head_pos = (head_pos + 1) % RING_SLOTS;
        occupancy--;
        if (!done) begin
          ring_slot[(head_pos + occupancy) % RING_SLOTS] = old_head;
          occupancy++;
        end
        slice_left = slice_len;
      end
      if (occupancy > 0) begin
        g.valid = 1'b1;
        g.index = ring_slot[head_pos];
        if (slice_left > 0) slice_left--;
      end else begin
        slice_left = '0;
      end
      due_grants.insert(due_grants.size(), g);
    endfunction

    function void check_result(logic [7:0] tdata, logic [1:0] tuser);
      grant_t got;
      grant_t want;
      got.valid   = tuser[0];
      got.index   = tdata[IDX_W-1:0];
      got.dropped = tuser[1];
      if (due_grants.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with nothing due: valid=%0b index=%0d dropped=%0b",
                   $realtime, got.valid, got.index, got.dropped);
        return;
      end
      want = due_grants[0];
      due_grants.delete(0);
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: mismatch: expected valid=%0b index=%0d dropped=%0b, ",
                    "got valid=%0b index=%0d dropped=%0b"},
                   $realtime, want.valid, want.index, want.dropped,
                   got.valid, got.index, got.dropped);
      end
    endfunction

    function int pending_count();
      return due_grants.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [TQ_W-1:0]  cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [7:0]       m_tdata;
  logic [1:0]       m_tuser;

  sched_scoreboard  sb;
  bit               gaps_on;
  bit               stalls_on;
  bit               long_hold_req;
  int               long_hold_left;
  int               stall_left;
  int               cycle_count;

  round_robin_scheduler_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_round_robin_scheduler_core failed");
      $finish;
    end
  end

  // Sample the result stream at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Drive m_tready at the falling edge: a long hold when asked for,
  // otherwise random stall bursts.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req  = 1'b0;
        long_hold_left = LONG_HOLD;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        m_tready = 1'b0;
      end else if (stalls_on && stall_left > 0) begin
        stall_left--;
        m_tready = 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(logic req, logic [IDX_W-1:0] idx, logic done);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = {3'b000, done, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_item(req, idx, done);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    s_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop valid, wait for every due result, then let the block settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_quantum(logic [TQ_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.slice_len = value;
  endtask

  // Random traffic in stretches of 30 items: fill-heavy, drain-heavy
  // with many finished heads, or balanced.
  task automatic random_phase(int n_items, bit with_pressure);
    int   mix;
    logic req;
    logic done;
    mix = 2;
    for (int i = 0; i < n_items; i++) begin
      if (i % 30 == 0) mix = $urandom_range(0, 2);
      if (with_pressure && i == n_items / 3) long_hold_req = 1'b1;
      if (mix == 0) begin
        req  = ($urandom_range(0, 3) != 0) ? REQ_ARRIVAL : REQ_TICK;
        done = ($urandom_range(0, 7) == 0);
      end else if (mix == 1) begin
        req  = ($urandom_range(0, 4) != 0) ? REQ_TICK : REQ_ARRIVAL;
        done = 1'($urandom_range(0, 1));
      end else begin
        req  = $urandom_range(0, 1) ? REQ_TICK : REQ_ARRIVAL;
        done = ($urandom_range(0, 5) == 0);
      end
      send_item(req, IDX_W'($urandom_range(0, 15)), done);
      if (gaps_on && $urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 18));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = REQ_ARRIVAL;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    long_hold_req  = 1'b0;
    long_hold_left = 0;
    stall_left     = 0;
    cycle_count    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset quantum.
    send_item(REQ_TICK, 4'd0, 1'b0);          // empty ring: idle, countdown zeroed
    send_item(REQ_TICK, 4'd15, 1'b1);         // empty ring with done: head check skipped
    send_item(REQ_ARRIVAL, 4'd15, 1'b0);
    send_item(REQ_TICK, 4'd0, 1'b1);          // lone head finishes: ring empties, idle
    for (int k = 0; k < RING_SLOTS; k++)      // fill the ring, indices 0 through 15
      send_item(REQ_ARRIVAL, k[IDX_W-1:0], k[0]);
    send_item(REQ_ARRIVAL, 4'd9, 1'b1);       // ring full: dropped
    send_item(REQ_TICK, 4'd15, 1'b0);         // zero countdown: rotate first
    send_item(REQ_TICK, 4'd0, 1'b0);
    send_item(REQ_TICK, 4'd7, 1'b1);          // finished head leaves for good
    send_item(REQ_ARRIVAL, 4'd10, 1'b0);
    send_item(REQ_ARRIVAL, 4'd11, 1'b0);      // full again: dropped
    drain();

    write_quantum(16'd1);                     // shortest slice
    random_phase(130, 1'b0);
    drain();

    write_quantum(16'd0);                     // countdown saturates, rotate every tick
    random_phase(100, 1'b0);
    drain();

    write_quantum(16'hFFFF);                  // longest slice; hold the output to back up
    random_phase(100, 1'b1);
    drain();

    write_quantum(TQ_W'($urandom_range(2, 9)));
    random_phase(130, 1'b0);
    drain();

    // Last stretch runs back to back with no idling on either side.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_quantum(16'd3);
    random_phase(120, 1'b0);
    drain();

    if (sb.fail_count == 0 && sb.pending_count() == 0) begin
      $display("tb_round_robin_scheduler_core passed");
    end else begin
      $display("tb_round_robin_scheduler_core failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rrs_pkg.sv
sv/rrs_ram.sv
sv/rrs_ctrl.sv
sv/rrs_dp.sv
sv/round_robin_scheduler_core.sv
test/tb_round_robin_scheduler_core.sv
